/* hdl/sclip_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rotated quad screen clipper.
// No dependencies; the cell, divider, top level and bench refer to it by scoped names.

package sclip_pkg;

   localparam int MAX_VERTS = 8;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 31;                 // stored vertex position width
   localparam int TEX_W     = FRAC_BITS + 1;      // Q1.FRAC_BITS texture coordinate
   localparam int OUT_POS_W = 28;
   localparam int BND_W     = 12 + FRAC_BITS;     // clip boundary in fixed point
   localparam int CNT_W     = $clog2(MAX_VERTS + 1);
   localparam int IDX_W     = $clog2(MAX_VERTS);
   localparam int DIV_W     = 32;

   localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << FRAC_BITS;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [OUT_POS_W-1:0] OUT_POS_MAX = {OUT_POS_W{1'b1}};

   // Configuration register indexes (byte address bit 2).
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;
   localparam logic [11:0] DEST_WIDTH_RST  = 12'd640;
   localparam logic [11:0] DEST_HEIGHT_RST = 12'd480;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [TEX_W-1:0]        s;
      logic [TEX_W-1:0]        t;
   } vtx_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CORNER,
      ST_SCAN,
      ST_CUT_GO,
      ST_CUT_WAIT,
      ST_CUT_PUSH,
      ST_PASS_END,
      ST_ALIGN,
      ST_COPY,
      ST_CHECK,
      ST_EMIT,
      ST_INVALID
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_RUN
   } div_state_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] diff;
      logic signed [DIV_W-1:0] num;
      logic signed [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [DIV_W:0] quo;
   } div_rsp_type;

   function automatic logic [DIV_W-1:0] abs_w(input logic signed [DIV_W-1:0] v);
      return v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [32:0] v);
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      hi = 33'(POS_MAX);
      lo = 33'(POS_MIN);
      if (v > hi) return POS_MAX;
      if (v < lo) return POS_MIN;
      return v[POS_W-1:0];
   endfunction

endpackage

/* hdl/sclip_req_if.sv */
`timescale 1ns / 1ps
// Input channel of the quad clipper: one rotated textured rectangle per transfer.
// Stands alone; carries valid, ready and the quad description.

interface sclip_req_if;
   logic               valid;
   logic               ready;
   logic signed [28:0] origin_x;
   logic signed [28:0] origin_y;
   logic signed [15:0] dir_cos;
   logic signed [15:0] dir_sin;
   logic [11:0]        tex_width;
   logic [11:0]        tex_height;

   modport source (output valid, origin_x, origin_y, dir_cos, dir_sin, tex_width,
                   tex_height, input ready);
   modport sink (input valid, origin_x, origin_y, dir_cos, dir_sin, tex_width,
                 tex_height, output ready);
endinterface

/* hdl/sclip_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the quad clipper: one clipped vertex per transfer.
// Stands alone; carries valid, ready and the vertex fields.

interface sclip_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] vert_x;
   logic [27:0] vert_y;
   logic [16:0] tex_s;
   logic [16:0] tex_t;
   logic        vert_valid;
   logic        last_vert;
   logic [3:0]  vert_total;

   modport source (output valid, vert_x, vert_y, tex_s, tex_t, vert_valid, last_vert,
                   vert_total, input ready);
   modport sink (input valid, vert_x, vert_y, tex_s, tex_t, vert_valid, last_vert,
                 vert_total, output ready);
endinterface

/* hdl/sclip_cell.sv */
`timescale 1ns / 1ps
// One vertex cell of a vertex chain: holds a vertex, takes its neighbor's
// vertex on a shift or a side vertex on a load. Depends on sclip_pkg.

module sclip_cell (
   input  logic                  clock,
   input  sclip_pkg::cell_op_type op,
   input  sclip_pkg::vtx_type    nb_vtx,
   input  sclip_pkg::vtx_type    ld_vtx,
   output sclip_pkg::vtx_type    vtx
);

   sclip_pkg::vtx_type vtx_ff;

   always_ff @(posedge clock) begin
      case (op)
         sclip_pkg::CELL_SHIFT: vtx_ff <= nb_vtx;
         sclip_pkg::CELL_LOAD:  vtx_ff <= ld_vtx;
         default:               vtx_ff <= vtx_ff;
      endcase
   end

   assign vtx = vtx_ff;

endmodule

/* hdl/sclip_div.sv */
`timescale 1ns / 1ps
// Interpolation unit: computes trunc(diff * num / den) with one multiply and a
// radix-2 restoring division, one quotient bit per cycle. Depends on sclip_pkg.

module sclip_div (
   input  logic                   clock,
   input  logic                   reset,
   input  sclip_pkg::div_req_type div_req,
   output sclip_pkg::div_rsp_type div_rsp
);

   localparam int W = sclip_pkg::DIV_W;

   sclip_pkg::div_state_type st_ff, st_in;
   logic                     neg_ff, neg_in;
   logic [W-1:0]             md_ff, md_in;
   logic [W-1:0]             mn_ff, mn_in;
   logic [W-1:0]             den_ff, den_in;
   logic [W-1:0]             rem_ff, rem_in;
   logic [W-1:0]             quo_ff, quo_in;
   logic [$clog2(W)-1:0]     cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [2*W-1:0]           prod;
   logic [W:0]               rem2;
   logic                     ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= sclip_pkg::DIV_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      md_ff  <= md_in;
      mn_ff  <= mn_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      st_in   = st_ff;
      neg_in  = neg_ff;
      md_in   = md_ff;
      mn_in   = mn_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      prod    = md_ff * mn_ff;
      rem2    = {rem_ff, quo_ff[W-1]};
      ge      = (rem2 >= {1'b0, den_ff});
      unique case (st_ff)
         sclip_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               neg_in = div_req.diff[W-1] ^ div_req.num[W-1] ^ div_req.den[W-1];
               md_in  = sclip_pkg::abs_w(div_req.diff);
               mn_in  = sclip_pkg::abs_w(div_req.num);
               den_in = sclip_pkg::abs_w(div_req.den);
               st_in  = sclip_pkg::DIV_MUL;
            end
         end
         sclip_pkg::DIV_MUL: begin
            // The quotient never exceeds |diff|, so the upper half is below den.
            rem_in = prod[2*W-1:W];
            quo_in = prod[W-1:0];
            cnt_in = '0;
            st_in  = sclip_pkg::DIV_RUN;
         end
         sclip_pkg::DIV_RUN: begin
            rem_in = ge ? W'(rem2 - {1'b0, den_ff}) : rem2[W-1:0];
            quo_in = {quo_ff[W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {$clog2(W){1'b1}}) begin
               done_in = 1'b1;
               st_in   = sclip_pkg::DIV_IDLE;
            end
         end
         default: st_in = sclip_pkg::DIV_IDLE;
      endcase
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

/* hdl/rotated_quad_screen_clipper_unit.sv */
`timescale 1ns / 1ps
// Rotated quad screen clipper, top level. Depends on sclip_pkg, sclip_req_if,
// sclip_rsp_if, sclip_cell and sclip_div.
//
// Usage: a quad (origin, unit direction, texture size) is transferred on req.
// The block builds the four textured corners and clips them against the
// screen edges y >= 0, x >= 0, x <= dest_width and y <= dest_height, then
// sends the surviving vertices on rsp, one per transfer, last_vert marking
// the final one. A culled or degenerate quad yields one result with
// vert_valid low and last_vert high.
// Sequence: corner setup (ST_MUL, ST_CORNER) after the transfer, then per clip
// pass a scan of each vertex, three interpolations per boundary crossing on the
// shared divider (one quotient bit per cycle) plus a store of the new vertex,
// and a realign and reload of the list. One check step follows, then emission
// of the vertices in order. req.ready is high only between quads.
// dest_width and dest_height are written on the csr_ port (byte addresses 0
// and 4) and reset to 640 and 480. Reset returns the block to idle with no
// result pending. A stalled receiver holds the result register and the
// emission waits; nothing is dropped.

module rotated_quad_screen_clipper_unit (
   input  logic        clock,
   input  logic        reset,
   sclip_req_if.sink   req,
   sclip_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NV = sclip_pkg::MAX_VERTS;
   localparam int PW = sclip_pkg::POS_W;
   localparam int TW = sclip_pkg::TEX_W;
   localparam int CW = sclip_pkg::CNT_W;
   localparam int IW = sclip_pkg::IDX_W;

   // Configuration.
   logic [11:0] dw_ff, dh_ff;
   logic        csr_wr;

   // Captured quad and products.
   logic signed [28:0] ox_ff, oy_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic [11:0]        w_ff, h_ff;
   logic signed [28:0] pcw_ff, pcw_in, psw_ff, psw_in, nsh_ff, nsh_in, pch_ff, pch_in;

   // Control.
   sclip_pkg::state_type state_ff, state_in;
   logic [CW-1:0] n_ff, n_in, m_ff, m_in;
   logic [IW-1:0] i_ff, i_in, rot_ff, rot_in;
   logic [1:0]    pass_ff, pass_in, fld_ff, fld_in;
   sclip_pkg::vtx_type first_ff, first_in, cut_ff, cut_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [27:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [16:0] rsp_s_ff, rsp_s_in, rsp_t_ff, rsp_t_in;
   logic        rsp_vv_ff, rsp_vv_in, rsp_last_ff, rsp_last_in;
   logic [3:0]  rsp_tot_ff, rsp_tot_in;

   // Vertex chains.
   sclip_pkg::vtx_type    a_vtx [NV];
   sclip_pkg::vtx_type    b_vtx [NV];
   sclip_pkg::vtx_type    corner [4];
   sclip_pkg::vtx_type    b_tail;
   sclip_pkg::cell_op_type a_op, b_op;
   logic                  a_from_corner;

   sclip_pkg::div_req_type div_req;
   sclip_pkg::div_rsp_type div_rsp;

   sclip_pkg::vtx_type cur, nxt;
   logic               last_i, in_cur, in_nxt, push1, cut_need, on_y, slot_free;
   logic [CW-1:0]      m_after;
   logic signed [31:0] bound, a0, a1;
   logic signed [32:0] cx0, cy0, cx1, cy1, cx2, cy2, cx3, cy3;
   logic signed [32:0] fsum;
   logic signed [PW-1:0] out_x, out_y;

   function automatic logic inside_f(input logic [1:0] p, input sclip_pkg::vtx_type v,
                                     input logic signed [31:0] b);
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      vx = 32'(v.x);
      vy = 32'(v.y);
      case (p)
         2'd0:    return vy >= 0;
         2'd1:    return vx >= 0;
         2'd2:    return vx <= b;
         default: return vy <= b;
      endcase
   endfunction

   function automatic logic [27:0] clamp_out(input logic signed [PW-1:0] v);
      if (v < 0) return '0;
      if (v > $signed(PW'(sclip_pkg::OUT_POS_MAX))) return sclip_pkg::OUT_POS_MAX;
      return v[27:0];
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff <= sclip_pkg::DEST_WIDTH_RST;
         dh_ff <= sclip_pkg::DEST_HEIGHT_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == sclip_pkg::CSR_IDX_WIDTH) dw_ff <= csr_pwdata[11:0];
         if (csr_paddr[2] == sclip_pkg::CSR_IDX_HEIGHT) dh_ff <= csr_pwdata[11:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sclip_pkg::CSR_IDX_WIDTH:  csr_prdata = {20'd0, dw_ff};
         sclip_pkg::CSR_IDX_HEIGHT: csr_prdata = {20'd0, dh_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- vertex chains ----------------
   for (genvar k = 0; k < NV; k++) begin : g_chain
      sclip_pkg::vtx_type a_ld;
      if (k < 4) begin : g_cor
         assign a_ld = a_from_corner ? corner[k] : b_vtx[k];
      end else begin : g_nocor
         assign a_ld = b_vtx[k];
      end
      sclip_cell u_a (
         .clock  (clock),
         .op     (a_op),
         .nb_vtx (a_vtx[(k + 1) % NV]),
         .ld_vtx (a_ld),
         .vtx    (a_vtx[k])
      );
      sclip_cell u_b (
         .clock  (clock),
         .op     (b_op),
         .nb_vtx ((k == NV - 1) ? b_tail : b_vtx[(k + 1) % NV]),
         .ld_vtx (b_vtx[k]),
         .vtx    (b_vtx[k])
      );
   end

   sclip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- corners ----------------
   always_comb begin
      cx0 = 33'(ox_ff);
      cy0 = 33'(oy_ff);
      cx1 = cx0 + 33'($signed({pcw_ff, 2'b00}));
      cy1 = cy0 + 33'($signed({psw_ff, 2'b00}));
      cx3 = cx0 + 33'($signed({nsh_ff, 2'b00}));
      cy3 = cy0 + 33'($signed({pch_ff, 2'b00}));
      cx2 = cx1 + 33'($signed({nsh_ff, 2'b00}));
      cy2 = cy1 + 33'($signed({pch_ff, 2'b00}));
      corner[0] = '{x: sclip_pkg::sat_pos(cx0), y: sclip_pkg::sat_pos(cy0),
                    s: '0, t: '0};
      corner[1] = '{x: sclip_pkg::sat_pos(cx1), y: sclip_pkg::sat_pos(cy1),
                    s: sclip_pkg::TEX_ONE, t: '0};
      corner[2] = '{x: sclip_pkg::sat_pos(cx2), y: sclip_pkg::sat_pos(cy2),
                    s: sclip_pkg::TEX_ONE, t: sclip_pkg::TEX_ONE};
      corner[3] = '{x: sclip_pkg::sat_pos(cx3), y: sclip_pkg::sat_pos(cy3),
                    s: '0, t: sclip_pkg::TEX_ONE};
   end

   // ---------------- clip datapath ----------------
   always_comb begin
      cur    = a_vtx[0];
      last_i = ({1'b0, i_ff} == n_ff - 1'b1);
      if (!last_i)        nxt = a_vtx[1];
      else if (i_ff == 0) nxt = a_vtx[0];
      else                nxt = first_ff;
      on_y = (pass_ff == 2'd0) || (pass_ff == 2'd3);
      case (pass_ff)
         2'd2:    bound = 32'(sclip_pkg::BND_W'(dw_ff) << sclip_pkg::FRAC_BITS);
         2'd3:    bound = 32'(sclip_pkg::BND_W'(dh_ff) << sclip_pkg::FRAC_BITS);
         default: bound = '0;
      endcase
      in_cur   = inside_f(pass_ff, cur, bound);
      in_nxt   = inside_f(pass_ff, nxt, bound);
      push1    = in_cur && (m_ff < CW'(NV));
      m_after  = m_ff + CW'(push1);
      cut_need = (in_cur != in_nxt) && (m_after < CW'(NV));
      a0 = on_y ? 32'(cur.y) : 32'(cur.x);
      a1 = on_y ? 32'(nxt.y) : 32'(nxt.x);
      div_req.start = (state_ff == sclip_pkg::ST_CUT_GO);
      div_req.num   = bound - a0;
      div_req.den   = a1 - a0;
      case (fld_ff)
         2'd0: begin
            div_req.diff = on_y ? 32'(nxt.x) - 32'(cur.x) : 32'(nxt.y) - 32'(cur.y);
            fsum = (on_y ? 33'(cur.x) : 33'(cur.y)) + div_rsp.quo;
         end
         2'd1: begin
            div_req.diff = 32'($signed({1'b0, nxt.s})) - 32'($signed({1'b0, cur.s}));
            fsum = 33'($signed({1'b0, cur.s})) + div_rsp.quo;
         end
         default: begin
            div_req.diff = 32'($signed({1'b0, nxt.t})) - 32'($signed({1'b0, cur.t}));
            fsum = 33'($signed({1'b0, cur.t})) + div_rsp.quo;
         end
      endcase
      out_x = a_vtx[0].x;
      out_y = a_vtx[0].y;
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sclip_pkg::ST_IDLE;
         n_ff         <= '0;
         m_ff         <= '0;
         i_ff         <= '0;
         rot_ff       <= '0;
         pass_ff      <= '0;
         fld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         m_ff         <= m_in;
         i_ff         <= i_in;
         rot_ff       <= rot_in;
         pass_ff      <= pass_in;
         fld_ff       <= fld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req.valid && req.ready) begin
         ox_ff  <= req.origin_x;
         oy_ff  <= req.origin_y;
         cos_ff <= req.dir_cos;
         sin_ff <= req.dir_sin;
         w_ff   <= req.tex_width;
         h_ff   <= req.tex_height;
      end
      pcw_ff      <= pcw_in;
      psw_ff      <= psw_in;
      nsh_ff      <= nsh_in;
      pch_ff      <= pch_in;
      first_ff    <= first_in;
      cut_ff      <= cut_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_s_ff    <= rsp_s_in;
      rsp_t_ff    <= rsp_t_in;
      rsp_vv_ff   <= rsp_vv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_tot_ff  <= rsp_tot_in;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      i_in          = i_ff;
      rot_in        = rot_ff;
      pass_in       = pass_ff;
      fld_in        = fld_ff;
      first_in      = first_ff;
      cut_in        = cut_ff;
      pcw_in        = pcw_ff;
      psw_in        = psw_ff;
      nsh_in        = nsh_ff;
      pch_in        = pch_ff;
      a_op          = sclip_pkg::CELL_HOLD;
      b_op          = sclip_pkg::CELL_HOLD;
      b_tail        = b_vtx[0];
      a_from_corner = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_s_in      = rsp_s_ff;
      rsp_t_in      = rsp_t_ff;
      rsp_vv_in     = rsp_vv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_tot_in    = rsp_tot_ff;

      unique case (state_ff)
         sclip_pkg::ST_IDLE: begin
            if (req.valid) state_in = sclip_pkg::ST_MUL;
         end
         sclip_pkg::ST_MUL: begin
            pcw_in   = 29'(cos_ff * $signed({1'b0, w_ff}));
            psw_in   = 29'(sin_ff * $signed({1'b0, w_ff}));
            nsh_in   = 29'(-(sin_ff * $signed({1'b0, h_ff})));
            pch_in   = 29'(cos_ff * $signed({1'b0, h_ff}));
            state_in = sclip_pkg::ST_CORNER;
         end
         sclip_pkg::ST_CORNER: begin
            a_op          = sclip_pkg::CELL_LOAD;
            a_from_corner = 1'b1;
            n_in          = CW'(4);
            m_in          = '0;
            i_in          = '0;
            pass_in       = '0;
            state_in      = sclip_pkg::ST_SCAN;
         end
         sclip_pkg::ST_SCAN: begin
            if (i_ff == 0) first_in = cur;
            if (push1) begin
               b_op   = sclip_pkg::CELL_SHIFT;
               b_tail = cur;
               m_in   = m_after;
            end
            if (cut_need) begin
               fld_in   = '0;
               state_in = sclip_pkg::ST_CUT_GO;
            end else begin
               a_op = sclip_pkg::CELL_SHIFT;
               if (last_i) state_in = sclip_pkg::ST_PASS_END;
               else        i_in = i_ff + 1'b1;
            end
         end
         sclip_pkg::ST_CUT_GO: begin
            state_in = sclip_pkg::ST_CUT_WAIT;
         end
         sclip_pkg::ST_CUT_WAIT: begin
            if (div_rsp.done) begin
               case (fld_ff)
                  2'd0: begin
                     // The crossed coordinate lands exactly on the boundary.
                     if (on_y) begin
                        cut_in.y = bound[PW-1:0];
                        cut_in.x = fsum[PW-1:0];
                     end else begin
                        cut_in.x = bound[PW-1:0];
                        cut_in.y = fsum[PW-1:0];
                     end
                  end
                  2'd1:    cut_in.s = fsum[TW-1:0];
                  default: cut_in.t = fsum[TW-1:0];
               endcase
               if (fld_ff == 2'd2) begin
                  state_in = sclip_pkg::ST_CUT_PUSH;
               end else begin
                  fld_in   = fld_ff + 1'b1;
                  state_in = sclip_pkg::ST_CUT_GO;
               end
            end
         end
         sclip_pkg::ST_CUT_PUSH: begin
            b_op   = sclip_pkg::CELL_SHIFT;
            b_tail = cut_ff;
            m_in   = m_ff + 1'b1;
            a_op   = sclip_pkg::CELL_SHIFT;
            if (last_i) begin
               state_in = sclip_pkg::ST_PASS_END;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = sclip_pkg::ST_SCAN;
            end
         end
         sclip_pkg::ST_PASS_END: begin
            if (m_ff == 0) begin
               state_in = sclip_pkg::ST_INVALID;
            end else begin
               // The new list sits at the tail of chain B; rotate it to the head.
               rot_in   = IW'(CW'(NV) - m_ff);
               state_in = sclip_pkg::ST_ALIGN;
            end
         end
         sclip_pkg::ST_ALIGN: begin
            if (rot_ff == 0) begin
               state_in = sclip_pkg::ST_COPY;
            end else begin
               b_op   = sclip_pkg::CELL_SHIFT;
               rot_in = rot_ff - 1'b1;
            end
         end
         sclip_pkg::ST_COPY: begin
            a_op    = sclip_pkg::CELL_LOAD;
            n_in    = m_ff;
            m_in    = '0;
            i_in    = '0;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == 2'd3) state_in = sclip_pkg::ST_CHECK;
            else                 state_in = sclip_pkg::ST_SCAN;
         end
         sclip_pkg::ST_CHECK: begin
            i_in = '0;
            if (n_ff < CW'(3)) state_in = sclip_pkg::ST_INVALID;
            else               state_in = sclip_pkg::ST_EMIT;
         end
         sclip_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = clamp_out(out_x);
               rsp_y_in     = clamp_out(out_y);
               rsp_s_in     = a_vtx[0].s;
               rsp_t_in     = a_vtx[0].t;
               rsp_vv_in    = 1'b1;
               rsp_last_in  = last_i;
               rsp_tot_in   = 4'(n_ff);
               a_op         = sclip_pkg::CELL_SHIFT;
               if (last_i) state_in = sclip_pkg::ST_IDLE;
               else        i_in = i_ff + 1'b1;
            end
         end
         sclip_pkg::ST_INVALID: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_s_in     = '0;
               rsp_t_in     = '0;
               rsp_vv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_tot_in   = '0;
               n_in         = '0;
               state_in     = sclip_pkg::ST_IDLE;
            end
         end
         default: state_in = sclip_pkg::ST_IDLE;
      endcase
   end

   assign req.ready      = (state_ff == sclip_pkg::ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.vert_x     = rsp_x_ff;
   assign rsp.vert_y     = rsp_y_ff;
   assign rsp.tex_s      = rsp_s_ff;
   assign rsp.tex_t      = rsp_t_ff;
   assign rsp.vert_valid = rsp_vv_ff;
   assign rsp.last_vert  = rsp_last_ff;
   assign rsp.vert_total = rsp_tot_ff;

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      m_ff <= CW'(NV))
      else $error("clip output list exceeds its capacity");

   a_valid_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vv_ff) |-> (rsp_tot_ff >= 4'd3))
      else $error("vertex sent for a polygon with fewer than three vertices");

   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_vv_ff) |-> rsp_last_ff)
      else $error("invalid result not marked last");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == sclip_pkg::ST_CUT_WAIT))
      else $error("divider finished outside an interpolation");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for rotated_quad_screen_clipper_unit: random and directed quads
// against a behavioral clipper, at the reset screen size and several more set on the csr_ port.
// Depends on sclip_pkg, sclip_req_if, sclip_rsp_if and the clipper RTL.

module tb;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic signed [28:0] origin_x;
      logic signed [28:0] origin_y;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
      logic [11:0]        tex_width;
      logic [11:0]        tex_height;
   } quad_type;

   typedef struct packed {
      logic [27:0] vert_x;
      logic [27:0] vert_y;
      logic [16:0] tex_s;
      logic [16:0] tex_t;
      logic        vert_valid;
      logic        last_vert;
      logic [3:0]  vert_total;
   } vert_type;

   typedef struct {
      longint x;
      longint y;
      longint s;
      longint t;
   } pt_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sclip_req_if req ();
   sclip_rsp_if rsp ();

   rotated_quad_screen_clipper_unit u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   quad_type quad_q[$];
   vert_type vertex_q[$];
   longint   screen_w = 640;
   longint   screen_h = 480;
   int       fail_cnt = 0;
   int       quads_sent = 0;
   int       verts_checked = 0;
   int       culled_seen = 0;
   int       idle_cycles = 0;
   int       req_gap = 0;
   int       rsp_gap = 0;
   logic     req_taken;
   logic     no_stall;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_stall || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Expected vertices of one quad, clipped against the current screen size.
   function automatic void clip_quad(input quad_type q);
      pt_type src[sclip_pkg::MAX_VERTS];
      pt_type dst[sclip_pkg::MAX_VERTS];
      pt_type a;
      pt_type b;
      pt_type r;
      bit     ins[sclip_pkg::MAX_VERTS];
      longint c, sn, w, h, xdw, ydw, xdh, ydh, one, bw, bh;
      longint bound, num, den, d;
      int     n, m, j;
      bit     on_y;
      vert_type v;
      one = 64'sd1 <<< sclip_pkg::FRAC_BITS;
      bw  = screen_w <<< sclip_pkg::FRAC_BITS;
      bh  = screen_h <<< sclip_pkg::FRAC_BITS;
      c   = longint'(q.dir_cos);
      sn  = longint'(q.dir_sin);
      w   = longint'(q.tex_width);
      h   = longint'(q.tex_height);
      // Q.14 to Q.16 is an exact shift by two, so no rounding is lost here.
      xdw = c * w * 4;
      ydw = sn * w * 4;
      xdh = -sn * h * 4;
      ydh = c * h * 4;
      src[0] = '{longint'(q.origin_x), longint'(q.origin_y), 0, 0};
      src[1] = '{src[0].x + xdw, src[0].y + ydw, one, 0};
      src[2] = '{src[0].x + xdw + xdh, src[0].y + ydw + ydh, one, one};
      src[3] = '{src[0].x + xdh, src[0].y + ydh, 0, one};
      for (int i = 0; i < 4; i++) begin
         if (src[i].x > 1073741823) src[i].x = 1073741823;
         if (src[i].x < -1073741824) src[i].x = -1073741824;
         if (src[i].y > 1073741823) src[i].y = 1073741823;
         if (src[i].y < -1073741824) src[i].y = -1073741824;
      end
      n = 4;
      for (int pass = 0; pass < 4; pass++) begin
         on_y  = (pass == 0 || pass == 3);
         bound = (pass == 2) ? bw : (pass == 3) ? bh : 0;
         for (int i = 0; i < n; i++) begin
            case (pass)
               0: d = src[i].y;
               1: d = src[i].x;
               2: d = bw - src[i].x;
               default: d = bh - src[i].y;
            endcase
            ins[i] = (d >= 0);
         end
         m = 0;
         for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if (ins[i] && m < sclip_pkg::MAX_VERTS) begin
               dst[m] = src[i];
               m++;
            end
            if (ins[i] != ins[j] && m < sclip_pkg::MAX_VERTS) begin
               a   = src[i];
               b   = src[j];
               num = bound - (on_y ? a.y : a.x);
               den = (on_y ? b.y : b.x) - (on_y ? a.y : a.x);
               if (den == 0) den = 1;
               r = a;
               if (on_y) begin
                  r.y = bound;
                  r.x = a.x + ((b.x - a.x) * num) / den;
               end else begin
                  r.x = bound;
                  r.y = a.y + ((b.y - a.y) * num) / den;
               end
               r.s = a.s + ((b.s - a.s) * num) / den;
               r.t = a.t + ((b.t - a.t) * num) / den;
               dst[m] = r;
               m++;
            end
         end
         if (m == 0) begin
            n = 0;
            break;
         end
         n = m;
         for (int i = 0; i < n; i++) src[i] = dst[i];
      end
      if (n < 3) begin
         v = '0;
         v.last_vert = 1'b1;
         vertex_q.push_back(v);
         return;
      end
      for (int k = 0; k < n; k++) begin
         v.vert_x = (src[k].x < 0) ? 28'd0 : (src[k].x > 64'hFFFFFFF) ? '1 : src[k].x[27:0];
         v.vert_y = (src[k].y < 0) ? 28'd0 : (src[k].y > 64'hFFFFFFF) ? '1 : src[k].y[27:0];
         v.tex_s  = (src[k].s < 0) ? 17'd0 : (src[k].s > 64'h1FFFF) ? '1 : src[k].s[16:0];
         v.tex_t  = (src[k].t < 0) ? 17'd0 : (src[k].t > 64'h1FFFF) ? '1 : src[k].t[16:0];
         v.vert_valid = 1'b1;
         v.last_vert  = (k == n - 1);
         v.vert_total = n[3:0];
         vertex_q.push_back(v);
      end
   endfunction

   // Input side: a new quad or a gap is chosen at the falling edge.
   always @(negedge clock) begin
      if (!reset && (!req.valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (quad_q.size() > 0) begin
            {req.origin_x, req.origin_y, req.dir_cos, req.dir_sin, req.tex_width,
             req.tex_height} <= quad_q.pop_front();
            req.valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // Acceptance on both channels and the result check.
   always @(posedge clock) begin
      vert_type got;
      vert_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req.valid && req.ready;
         if (req.valid && req.ready) begin
            clip_quad({req.origin_x, req.origin_y, req.dir_cos, req.dir_sin,
                       req.tex_width, req.tex_height});
            quads_sent++;
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.vert_x, rsp.vert_y, rsp.tex_s, rsp.tex_t, rsp.vert_valid,
                   rsp.last_vert, rsp.vert_total};
            if (vertex_q.size() == 0) begin
               $display("%0t: unexpected vertex transfer %h", $time, got);
               fail_cnt++;
            end else begin
               want = vertex_q.pop_front();
               verts_checked++;
               if (!want.vert_valid) culled_seen++;
               if (got.vert_x !== want.vert_x)
                  $display("%0t: vert_x exp %h got %h", $time, want.vert_x, got.vert_x);
               if (got.vert_y !== want.vert_y)
                  $display("%0t: vert_y exp %h got %h", $time, want.vert_y, got.vert_y);
               if (got.tex_s !== want.tex_s)
                  $display("%0t: tex_s exp %h got %h", $time, want.tex_s, got.tex_s);
               if (got.tex_t !== want.tex_t)
                  $display("%0t: tex_t exp %h got %h", $time, want.tex_t, got.tex_t);
               if (got.vert_valid !== want.vert_valid)
                  $display("%0t: vert_valid exp %b got %b", $time, want.vert_valid,
                           got.vert_valid);
               if (got.last_vert !== want.last_vert)
                  $display("%0t: last_vert exp %b got %b", $time, want.last_vert,
                           got.last_vert);
               if (got.vert_total !== want.vert_total)
                  $display("%0t: vert_total exp %0d got %0d", $time, want.vert_total,
                           got.vert_total);
               if (got !== want) fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("rotated_quad_screen_clipper_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic idx, input logic [11:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {20'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == sclip_pkg::CSR_IDX_WIDTH) screen_w = longint'(value);
      else screen_h = longint'(value);
   endtask

   task automatic add_quad(input int ox, input int oy, input int c, input int sn,
                           input int w, input int h);
      quad_type q;
      q.origin_x   = ox[28:0];
      q.origin_y   = oy[28:0];
      q.dir_cos    = c[15:0];
      q.dir_sin    = sn[15:0];
      q.tex_width  = w[11:0];
      q.tex_height = h[11:0];
      quad_q.push_back(q);
   endtask

   // Mostly quads near the screen with unit-ish directions; some raw noise.
   task automatic add_random_quads(input int count);
      int ang;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_quad($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            ang = $urandom_range(0, 7);
            add_quad((int'($urandom_range(0, 1400)) - 300) * 65536 + $urandom_range(0, 65535),
                     (int'($urandom_range(0, 1100)) - 300) * 65536 + $urandom_range(0, 65535),
                     (ang < 2) ? 16384 : (ang < 4) ? -16384 :
                        int'($urandom_range(0, 32768)) - 16384,
                     (ang == 1 || ang == 3) ? 0 : int'($urandom_range(0, 32768)) - 16384,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 600),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 600));
         end
      end
   endtask

   task automatic drain();
      while (quad_q.size() > 0 || req.valid || vertex_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      no_stall    = 1'b0;
      req.valid   = 1'b0;
      req.origin_x = '0;
      req.origin_y = '0;
      req.dir_cos  = '0;
      req.dir_sin  = '0;
      req.tex_width  = '0;
      req.tex_height = '0;
      rsp.ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed quads at the reset screen size.
      add_quad(100 << 16, 100 << 16, 16384, 0, 200, 100);     // fully inside
      add_quad(-268435456, -268435456, 16384, 16384, 4095, 4095);
      add_quad(268435455, 268435455, -16384, -16384, 4095, 4095);
      add_quad(-268435456, 268435455, 16384, -16384, 4095, 0);
      add_quad(320 << 16, 240 << 16, 11585, 11585, 600, 600);  // rotated, cut on three sides
      add_quad(-500 << 16, 100 << 16, 16384, 0, 100, 100);     // culled left of screen
      add_quad(100 << 16, 0, -16384, 0, 10, 10);               // only an edge on y = 0
      add_quad(50 << 16, 50 << 16, 16384, 0, 0, 0);            // zero size
      add_quad(0, 0, 16384, 0, 640, 480);                      // exactly the screen
      add_quad(600 << 16, 400 << 16, 0, 16384, 4095, 4095);
      add_quad(10 << 16, 10 << 16, 32767, -32768, 20, 30);     // not a unit vector
      add_quad(300 << 16, 200 << 16, -16384, 16384, 50, 4095);
      add_random_quads(45);
      drain();

      csr_write(sclip_pkg::CSR_IDX_WIDTH, 12'd1);
      csr_write(sclip_pkg::CSR_IDX_HEIGHT, 12'd1);
      add_random_quads(40);
      drain();

      csr_write(sclip_pkg::CSR_IDX_WIDTH, 12'd4095);
      csr_write(sclip_pkg::CSR_IDX_HEIGHT, 12'd4095);
      no_stall = 1'b1;
      add_random_quads(50);
      drain();

      no_stall = 1'b0;
      csr_write(sclip_pkg::CSR_IDX_WIDTH, 12'd4095);
      csr_write(sclip_pkg::CSR_IDX_HEIGHT, 12'd1);
      add_random_quads(40);
      drain();

      for (int p = 0; p < 3; p++) begin
         csr_write(sclip_pkg::CSR_IDX_WIDTH, 12'($urandom_range(1, 4095)));
         csr_write(sclip_pkg::CSR_IDX_HEIGHT, 12'($urandom_range(1, 4095)));
         add_random_quads(45);
         drain();
      end

      $display("Covered %0d quads and %0d checked vertex transfers (%0d culled results),",
               quads_sent, verts_checked, culled_seen);
      $display("over seven screen sizes including the smallest and largest.");
      if (fail_cnt == 0) begin
         $display("rotated_quad_screen_clipper_unit verification clean");
      end else begin
         $display("rotated_quad_screen_clipper_unit verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/sclip_pkg.sv
hdl/sclip_req_if.sv
hdl/sclip_rsp_if.sv
hdl/sclip_cell.sv
hdl/sclip_div.sv
hdl/rotated_quad_screen_clipper_unit.sv
bench/tb.sv
